@@ design/gmt_pkg.sv @@
// Shared types and constants for the grid mesh tessellation unit.
// No dependencies.
`timescale 1ns / 1ps

package gmt_pkg;

  localparam int ROW_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(ROW_DEPTH);
  localparam int WIDTH_W   = 11;
  localparam int IDX_W     = 16;
  localparam int LEAK_W    = 32;
  localparam int EPOCH_W   = 4;
  localparam int SLOT_N    = 10;

  typedef struct packed {
    logic             occ;
    logic             hull;
    logic [IDX_W-1:0] idx;
  } cell_t;

  typedef struct packed {
    cell_t below;
    cell_t middle;
  } row_pair_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    row_pair_t          pair;
  } row_entry_t;

  typedef struct packed {
    logic  frame_start;
    cell_t pt;
  } item_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_stat_t;

  typedef enum logic [1:0] {
    KIND_LEAK   = 2'd0,
    KIND_SPRING = 2'd1,
    KIND_TRI    = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    SLOT_LEAK     = 4'd0,
    SLOT_SPR_E    = 4'd1,
    SLOT_TRI_E    = 4'd2,
    SLOT_TRI_ES   = 4'd3,
    SLOT_SPR_SE   = 4'd4,
    SLOT_TRI_SE   = 4'd5,
    SLOT_SPR_S    = 4'd6,
    SLOT_TRI_S    = 4'd7,
    SLOT_SPR_SW   = 4'd8,
    SLOT_TRI_SW   = 4'd9
  } slot_e;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  second;
    logic [IDX_W-1:0]  third;
    logic [LEAK_W-1:0] leak;
    logic              last;
  } record_t;

endpackage

@@ design/gmt_front.sv @@
// Input side: takes cell beats, packs them into cells and queues them.
// Depends on gmt_pkg.
`timescale 1ns / 1ps

module gmt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [23:0]        s_tdata,   // occupied, point_index[15:0], is_hull, pad
  input  logic [0:0]         s_tuser,   // frame_start
  input  gmt_pkg::back_stat_t stat_i,
  output gmt_pkg::item_t     head_o,
  output logic               head_valid_o
);
  import gmt_pkg::*;

  item_t      q_mem [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      in_item;

  assign s_tready     = (cnt_q != 2'd2) && !stat_i.init_busy;
  assign push         = s_tvalid && s_tready;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = q_mem[rd_ptr_q];

  always_comb begin
    in_item.frame_start = s_tuser[0];
    in_item.pt.occ      = s_tdata[0];
    in_item.pt.hull     = s_tdata[0] & s_tdata[17];
    in_item.pt.idx      = s_tdata[0] ? s_tdata[16:1] : '0;
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ stat_i.pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, stat_i.pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ design/gmt_back.sv @@
// Back end: row buffer memory, per-cell sequencer, record generation and
// output register. Depends on gmt_pkg.
`timescale 1ns / 1ps

module gmt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gmt_pkg::WIDTH_W-1:0]   width_i,
  input  gmt_pkg::item_t                head_i,
  input  logic                          head_valid_i,
  output gmt_pkg::back_stat_t           stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gmt_pkg::record_t              out_o
);
  import gmt_pkg::*;

  row_entry_t          mem [ROW_DEPTH];
  row_entry_t          rd_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic                we;
  logic [ADDR_W-1:0]   wr_addr;
  row_entry_t          wr_data;

  back_state_e         st_q, st_d;
  logic [ADDR_W-1:0]   col_q, col_d, x_q, x_d, clr_q, clr_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic                mv_q, mv_d, ship_q, ship_d, fsd_q, fsd_d, init_q, init_d;
  logic [LEAK_W-1:0]   leak_q, leak_d;
  cell_t               held_q, held_d;
  row_pair_t           w_q, w_d, c_q, c_d, e_q, e_d;
  logic [SLOT_N-1:0]   mask_q, mask_d;
  logic                ov_q, ov_d;
  record_t             out_q, out_d;

  logic [ADDR_W-1:0]   x_eff;
  logic [WIDTH_W-1:0]  x_plus;
  logic                last_col, ship_eff, active, out_free;
  row_pair_t           view, e_view;
  logic [SLOT_N-1:0]   m, pick, rest;
  slot_e               slot;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    view     = (rd_q.tag == epoch_q) ? rd_q.pair : '0;
    x_eff    = (head_i.frame_start || ({1'b0, col_q} >= width_i)) ? '0 : col_q;
    x_plus   = {1'b0, x_q} + WIDTH_W'(1);
    last_col = x_plus == width_i;
    e_view   = (x_plus < width_i) ? view : '0;
    ship_eff = (x_q != '0) && ship_q;
    active   = mv_q && c_q.middle.occ;
    m = '0;
    m[SLOT_LEAK]   = !c_q.middle.hull && (!e_view.middle.occ || !head_i.pt.occ ||
                     !w_q.middle.occ || !c_q.below.occ);
    m[SLOT_SPR_E]  = e_view.middle.occ;
    m[SLOT_TRI_E]  = e_view.middle.occ && e_view.below.occ;
    m[SLOT_TRI_ES] = e_view.middle.occ && !e_view.below.occ && c_q.below.occ;
    m[SLOT_SPR_SE] = e_view.below.occ;
    m[SLOT_TRI_SE] = e_view.below.occ && c_q.below.occ;
    m[SLOT_SPR_S]  = c_q.below.occ;
    m[SLOT_TRI_S]  = c_q.below.occ && !ship_eff && w_q.below.occ;
    m[SLOT_SPR_SW] = w_q.below.occ;
    m[SLOT_TRI_SW] = w_q.below.occ && !ship_eff && w_q.middle.occ;
    if (!active) m = '0;
    pick = mask_q & (~mask_q + SLOT_N'(1));
    rest = mask_q & ~pick;
    slot = SLOT_LEAK;
    for (int i = SLOT_N - 1; i >= 0; i--) begin
      if (mask_q[i]) slot = slot_e'(i);
    end
  end

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    st_d = st_q; col_d = col_q; x_d = x_q; clr_d = clr_q; epoch_d = epoch_q;
    mv_d = mv_q; ship_d = ship_q; fsd_d = fsd_q; init_d = init_q; leak_d = leak_q;
    held_d = held_q; w_d = w_q; c_d = c_q; e_d = e_q; mask_d = mask_q;
    ov_d = ov_q && !out_ready_i; out_d = out_q;
    rd_addr = x_q; we = 1'b0; wr_addr = x_q; wr_data = '0;
    stat_o.pop = 1'b0;
    stat_o.init_busy = init_q;
    case (st_q)
      ST_CLR: begin
        we = 1'b1;
        wr_addr = clr_q;
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(ROW_DEPTH - 1)) begin
          st_d = ST_RD0;
          fsd_d = 1'b1;
          init_d = 1'b0;
        end
      end
      ST_RD0: begin
        rd_addr = x_eff - ADDR_W'(1);
        if (head_valid_i) begin
          x_d = x_eff;
          st_d = ST_RD1;
          if (head_i.frame_start) begin
            col_d = '0; mv_d = 1'b0; ship_d = 1'b0; leak_d = '0; held_d = '0;
            if (!fsd_q) begin
              epoch_d = epoch_q + EPOCH_W'(1);
              if (epoch_q == '1) begin
                st_d = ST_CLR;
                clr_d = '0;
              end
            end
          end
        end
      end
      ST_RD1: begin
        w_d = (x_q != '0) ? view : '0;
        rd_addr = x_q;
        st_d = ST_RD2;
      end
      ST_RD2: begin
        c_d = view;
        rd_addr = x_plus[ADDR_W-1:0];
        we = x_q != '0;
        wr_addr = x_q - ADDR_W'(1);
        wr_data.tag = epoch_q;
        wr_data.pair.below = w_q.middle;
        wr_data.pair.middle = held_q;
        st_d = ST_RD3;
      end
      ST_RD3: begin
        e_d = e_view;
        mask_d = m;
        if (m[SLOT_LEAK] && leak_q != '1) leak_d = leak_q + LEAK_W'(1);
        we = last_col;
        wr_addr = x_q;
        wr_data.tag = epoch_q;
        wr_data.pair.below = c_q.middle;
        wr_data.pair.middle = head_i.pt;
        col_d = last_col ? '0 : x_plus[ADDR_W-1:0];
        mv_d = mv_q || last_col;
        ship_d = active;
        held_d = head_i.pt;
        fsd_d = 1'b0;
        stat_o.pop = 1'b1;
        st_d = (m != '0) ? ST_EMIT : ST_RD0;
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1;
          mask_d = rest;
          out_d.first = c_q.middle.idx;
          out_d.leak = leak_q;
          out_d.last = rest == '0;
          out_d.second = '0;
          out_d.third = '0;
          out_d.kind = KIND_TRI;
          case (slot)
            SLOT_LEAK:   out_d.kind = KIND_LEAK;
            SLOT_SPR_E:  begin out_d.kind = KIND_SPRING; out_d.second = e_q.middle.idx; end
            SLOT_TRI_E:  begin
              out_d.second = e_q.middle.idx; out_d.third = e_q.below.idx;
            end
            SLOT_TRI_ES: begin
              out_d.second = e_q.middle.idx; out_d.third = c_q.below.idx;
            end
            SLOT_SPR_SE: begin out_d.kind = KIND_SPRING; out_d.second = e_q.below.idx; end
            SLOT_TRI_SE: begin
              out_d.second = e_q.below.idx; out_d.third = c_q.below.idx;
            end
            SLOT_SPR_S:  begin out_d.kind = KIND_SPRING; out_d.second = c_q.below.idx; end
            SLOT_TRI_S:  begin
              out_d.second = c_q.below.idx; out_d.third = w_q.below.idx;
            end
            SLOT_SPR_SW: begin out_d.kind = KIND_SPRING; out_d.second = w_q.below.idx; end
            SLOT_TRI_SW: begin
              out_d.second = w_q.below.idx; out_d.third = w_q.middle.idx;
            end
            default: out_d.kind = KIND_LEAK;
          endcase
          if (rest == '0) st_d = ST_RD0;
        end
      end
      default: st_d = ST_RD0;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    x_q <= x_d; held_q <= held_d; w_q <= w_d; c_q <= c_d; e_q <= e_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLR; col_q <= '0; clr_q <= '0; epoch_q <= '0;
      mv_q <= 1'b0; ship_q <= 1'b0; fsd_q <= 1'b0; init_q <= 1'b1;
      leak_q <= '0; mask_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; col_q <= col_d; clr_q <= clr_d; epoch_q <= epoch_d;
      mv_q <= mv_d; ship_q <= ship_d; fsd_q <= fsd_d; init_q <= init_d;
      leak_q <= leak_d; mask_q <= mask_d; ov_q <= ov_d;
    end
  end

endmodule

@@ design/grid_mesh_tessellation_unit.sv @@
// Grid mesh tessellation unit: takes occupancy grid cells in raster order
// (bottom row first, one empty row appended by the host) and streams leak,
// spring and triangle records for each occupied cell of the row behind.
// In the back end a cell passes states RD0 to RD3, then yields n records (0 to 9):
// RD0 to RD3 make the three reads of the row memory's single read port, then
// one record leaves per cycle while the output is not stalled. After reset all
// 1024 row memory entries are swept with no cell taken; every 16th frame start sweeps it again.
// Depends on gmt_pkg, gmt_front and gmt_back.
`timescale 1ns / 1ps

module grid_mesh_tessellation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // occupied, point_index[15:0], is_hull, pad
  input  logic [0:0]  s_tuser,   // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // first_point, second_point, third_point, leak_count
  output logic [1:0]  m_tuser,   // record_kind
  output logic        m_tlast    // last_record
);
  import gmt_pkg::*;

  logic [WIDTH_W-1:0] row_width_q, row_width_d, width_eff;
  logic               wr_en;
  item_t              head;
  logic               head_valid;
  back_stat_t         stat;
  record_t            rec;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32-WIDTH_W){1'b0}}, row_width_q} : '0;
  assign row_width_d = wr_en ? pwdata[WIDTH_W-1:0] : row_width_q;

  always_comb begin
    width_eff = row_width_q;
    if (row_width_q == '0) width_eff = WIDTH_W'(1);
    if (row_width_q > WIDTH_W'(ROW_DEPTH)) width_eff = WIDTH_W'(ROW_DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= WIDTH_W'(ROW_DEPTH);
    end else begin
      row_width_q <= row_width_d;
    end
  end

  gmt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .stat_i       (stat),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  gmt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_i      (width_eff),
    .head_i       (head),
    .head_valid_i (head_valid),
    .stat_o       (stat),
    .out_valid_o  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_o        (rec)
  );

  assign m_tdata = {rec.leak, rec.third, rec.second, rec.first};
  assign m_tuser = rec.kind;
  assign m_tlast = rec.last;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for grid_mesh_tessellation_unit: streams occupancy grids
// through the slave port and checks every leak, spring and triangle beat against a
// built-in predictor. Depends on gmt_pkg and the unit RTL.
`timescale 1ns / 1ps

module testbench;
  import gmt_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [2:0] ADDR_ROW_WIDTH = 3'd0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  grid_mesh_tessellation_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mesh predictor state: cell = {occ, hull, idx}
  logic [17:0] below_cells [ROW_DEPTH];
  logic [17:0] middle_cells [ROW_DEPTH];
  logic [17:0] held_cell;
  int          col_pos;
  bit          middle_ok;
  bit          ship_run;
  logic [31:0] leak_total;
  logic [10:0] row_width;

  record_t     record_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic clear_mesh();
    for (int i = 0; i < ROW_DEPTH; i++) begin
      below_cells[i] = '0;
      middle_cells[i] = '0;
    end
    held_cell = '0;
    col_pos = 0;
    middle_ok = 0;
    ship_run = 0;
    leak_total = '0;
  endtask

  function automatic logic [17:0] cell_get(input bit mid, input int x, input int w);
    if (x < 0 || x >= w) return '0;
    return mid ? middle_cells[x] : below_cells[x];
  endfunction

  task automatic push_record(ref record_t recs[$], input kind_e k,
                             input logic [15:0] a, b, c);
    record_t r;
    r.kind = k; r.first = a; r.second = b; r.third = c; r.leak = '0; r.last = 1'b0;
    recs.insert(recs.size(), r);
  endtask

  task automatic predict_cell(input bit fs, input bit occ, input logic [15:0] idx,
                              input bit hull);
    logic [17:0] cur, c;
    logic [17:0] nb [5];
    record_t recs [$];
    int w, x;
    if (fs) clear_mesh();
    cur = occ ? {1'b1, hull, idx} : 18'd0;
    w = (row_width == 0) ? 1 : ((row_width > ROW_DEPTH) ? ROW_DEPTH : int'(row_width));
    if (col_pos >= w) col_pos = 0;
    x = col_pos;
    if (x == 0) ship_run = 0;
    c = cell_get(1, x, w);
    if (middle_ok && c[17]) begin
      nb[0] = cell_get(1, x + 1, w);
      nb[1] = cell_get(0, x + 1, w);
      nb[2] = cell_get(0, x, w);
      nb[3] = cell_get(0, x - 1, w);
      nb[4] = cell_get(1, x - 1, w);
      if (!c[16] && (!nb[0][17] || !cur[17] || !nb[4][17] || !nb[2][17])) begin
        if (leak_total != 32'hFFFF_FFFF) leak_total++;
        push_record(recs, KIND_LEAK, c[15:0], 16'd0, 16'd0);
      end
      for (int i = 0; i < 4; i++) begin
        if (nb[i][17]) begin
          push_record(recs, KIND_SPRING, c[15:0], nb[i][15:0], 16'd0);
          if ((!ship_run || i < 2) && nb[i+1][17])
            push_record(recs, KIND_TRI, c[15:0], nb[i][15:0], nb[i+1][15:0]);
          if (i == 0 && !nb[1][17] && nb[2][17])
            push_record(recs, KIND_TRI, c[15:0], nb[0][15:0], nb[2][15:0]);
        end
      end
      ship_run = 1;
    end else begin
      ship_run = 0;
    end
    if (x > 0) begin
      below_cells[x-1] = middle_cells[x-1];
      middle_cells[x-1] = held_cell;
    end
    held_cell = cur;
    if (x == w - 1) begin
      below_cells[x] = middle_cells[x];
      middle_cells[x] = cur;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      middle_ok = 1;
    end
    foreach (recs[k]) begin
      recs[k].leak = leak_total;
      recs[k].last = (k == recs.size() - 1);
      record_q.insert(record_q.size(), recs[k]);
    end
  endtask

  task automatic send_cell(input bit fs, input bit occ, input logic [15:0] idx,
                           input bit hull);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, hull, idx, occ};
    s_tuser <= fs;
    do @(posedge clk_i); while (!s_tready);
    predict_cell(fs, occ, idx, hull);
  endtask

  // hold off long enough for a queued cell to outlast a row memory sweep
  task automatic drain();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (record_q.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [10:0] v);
    drain();
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_ROW_WIDTH; pwdata <= {21'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    row_width = v;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // h rows of w cells plus the trailing empty row
  task automatic send_frame(input int w, input int h, input int density, input bit fs);
    for (int y = 0; y <= h; y++)
      for (int x = 0; x < w; x++)
        send_cell(fs && x == 0 && y == 0,
                  y < h && $urandom_range(0, 99) < density,
                  16'($urandom), 1'($urandom_range(0, 3) == 0));
  endtask

  task automatic test_full_grid();
    write_width(11'd3);
    for (int i = 0; i < 9; i++)
      send_cell(i == 0, i < 6, (i == 0) ? 16'h0000 : (i == 4 ? 16'hFFFF : 16'(i)), i == 4);
    drain();
  endtask

  task automatic test_triangle_cases();
    // E-S triangle with empty SE, run start vs in-run
    write_width(11'd3);
    send_cell(1, 1, 16'h0011, 0); send_cell(0, 1, 16'h0012, 1); send_cell(0, 0, 0, 0);
    send_cell(0, 1, 16'h0021, 0); send_cell(0, 1, 16'h0022, 0); send_cell(0, 1, 16'h0023, 1);
    send_cell(0, 0, 16'hABCD, 1); send_cell(0, 0, 0, 0); send_cell(0, 0, 0, 0);
  endtask

  task automatic test_width_extremes();
    write_width(11'd1);
    send_cell(1, 1, 16'h1234, 0); send_cell(0, 1, 16'h5678, 1); send_cell(0, 0, 0, 0);
    write_width(11'd0);
    send_cell(1, 1, 16'h0001, 1); send_cell(0, 1, 16'h0002, 0); send_cell(0, 0, 0, 0);
    write_width(11'd2047);
    send_cell(1, 1, 16'h00AA, 0); send_cell(0, 1, 16'h00BB, 1);
  endtask

  task automatic test_width_change_mid_row();
    write_width(11'd4);
    send_cell(1, 1, 16'h0101, 0); send_cell(0, 1, 16'h0102, 0);
    send_cell(0, 1, 16'h0103, 1);
    write_width(11'd2);
    send_cell(0, 1, 16'h0201, 0); send_cell(0, 1, 16'h0202, 0);
    send_cell(0, 0, 0, 0); send_cell(0, 0, 0, 0);
  endtask

  task automatic test_random();
    int items;
    items = 0;
    while (items < 250) begin
      int w, h;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      write_width(11'(w));
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < 5; i++)
          send_cell($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), 16'($urandom),
                    1'($urandom));
        items += 5;
      end
      send_frame(w, h, $urandom_range(40, 100), 1);
      items += w * (h + 1);
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();
  endtask

  // receiver stall pattern: ready, random, or mostly stalled stretches
  int ready_mode = 0, ready_len = 0;
  always @(negedge clk_i) begin
    if (ready_len == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_len = $urandom_range(10, 60);
    end
    ready_len--;
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom);
      default: m_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  always @(posedge clk_i) begin
    record_t want;
    cycles++;
    if (m_tvalid && m_tready) begin
      if (record_q.size() == 0) begin
        report("unexpected beat", 32'(m_tdata[15:0]), 32'd0);
      end else begin
        want = record_q.pop_front();
        if (m_tuser != want.kind) report("record_kind", 32'(m_tuser), 32'(want.kind));
        if (m_tdata[15:0] != want.first)
          report("first_point", 32'(m_tdata[15:0]), 32'(want.first));
        if (m_tdata[31:16] != want.second)
          report("second_point", 32'(m_tdata[31:16]), 32'(want.second));
        if (m_tdata[47:32] != want.third)
          report("third_point", 32'(m_tdata[47:32]), 32'(want.third));
        if (m_tdata[79:48] != want.leak) report("leak_count", m_tdata[79:48], want.leak);
        if (m_tlast != want.last) report("last_record", 32'(m_tlast), 32'(want.last));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clear_mesh();
    row_width = 11'd1024;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_full_grid();
    test_triangle_cases();
    test_width_extremes();
    test_width_change_mid_row();
    test_random();
    drain();
    if (record_q.size() != 0) report("missing beats", 32'(record_q.size()), 32'd0);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
